### hdl/optical_autobaud_frame_receiver_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the optical autobaud frame receiver
// Short wrappers around concurrent assertions with reset disable.
// ----------------------------------------------------------------------------
`ifndef OPTICAL_AUTOBAUD_FRAME_RECEIVER_ASSERT_SVH
`define OPTICAL_AUTOBAUD_FRAME_RECEIVER_ASSERT_SVH

// Antecedent in this cycle implies consequent in the next cycle.
`define OAFR_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define OAFR_ASSERT_SAME(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

### hdl/oafr_pkg.sv
// ----------------------------------------------------------------------------
// oafr_pkg
// Types and constants shared by the optical autobaud frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package oafr_pkg;

  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int FRAME_BITS  = 56;
  localparam int CALIB_MAX   = 1024;

  localparam logic [CFG_ADDR_W-1:0] CFG_SETTLE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CSAMPLES = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_MINEDGES = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_NPAD     = 2'd3;

  localparam logic [7:0] YEAR_MAX   = 8'd63;
  localparam logic [7:0] MONTH_MAX  = 8'd12;
  localparam logic [7:0] DAY_MAX    = 8'd31;
  localparam logic [7:0] HOUR_MAX   = 8'd23;
  localparam logic [7:0] MINSEC_MAX = 8'd59;

  typedef enum logic [2:0] {
    PH_CAL    = 3'd0,
    PH_LISTEN = 3'd1,
    PH_PRE    = 3'd2,
    PH_DATA   = 3'd3,
    PH_OK     = 3'd4,
    PH_ERR    = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DSTART,
    ST_DWAIT,
    ST_FIN,
    ST_OUT
  } ctl_state_t;

  typedef struct packed {
    logic        action;
    logic [15:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [5:0]  bit_count;
    logic [15:0] period_ticks;
    logic [15:0] level_threshold;
    logic [7:0]  year_field;
    logic [7:0]  month_field;
    logic [7:0]  day_field;
    logic [7:0]  hour_field;
    logic [7:0]  minute_field;
    logic [7:0]  second_field;
    logic        sum_ok;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic fin;
    logic load_out;
  } oafr_cmd_t;

  typedef struct packed {
    logic need_div;
    logic out_free;
  } oafr_sts_t;

endpackage

`default_nettype wire

### hdl/optical_autobaud_frame_receiver.sv
// ----------------------------------------------------------------------------
// optical_autobaud_frame_receiver
// Light-sensor frame decoder with self-calibrated threshold and bit period.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_data): one word per sensor tick, or a
//   restart word (action set). Every input word yields exactly one result word
//   on the out channel (out_valid/out_stall/out_data) showing the decoder state
//   after that word. Configuration (cfg_we/cfg_addr/cfg_wdata) must be written
//   by the user only while the block idles; the block does not enforce this.
// Sequencing and throughput:
//   A plain word is captured, executed and then loaded into the result
//   register before the next word is taken. The word that ends calibration,
//   and each preamble edge once min_edges is met, also runs the shared
//   32-step restoring divider before its result is loaded. One word is in
//   work at a time; the divider sets the worst case.
// Reset: rst_n (synchronous) restores register defaults, clears the decoder
//   to the calibrate phase and empties the result register.
// Stall: a result held by out_stall keeps its word; the next input word is
//   still accepted and worked on, then waits until the result register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module optical_autobaud_frame_receiver #(
  parameter int DATA_BITS    = 56,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire oafr_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output oafr_pkg::out_item_t                  out_data,
  input  wire logic                            cfg_we,
  input  wire logic [oafr_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [oafr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import oafr_pkg::*;

  // controller to datapath commands and status back
  oafr_cmd_t   cmd;
  oafr_sts_t   sts;

  // shared divider hookup
  logic        div_start;
  logic        div_done;
  logic [31:0] div_dividend;
  logic [15:0] div_divisor;
  logic [31:0] div_quot;

  oafr_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .sts       (sts),
    .div_start (div_start),
    .div_done  (div_done)
  );

  oafr_dp #(
    .DATA_BITS    (DATA_BITS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_data      (in_data),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_quot     (div_quot),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

  // baseline mean and bit period share this unit
  oafr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot)
  );

endmodule

`default_nettype wire

### hdl/oafr_div.sv
// ----------------------------------------------------------------------------
// oafr_div
// Restoring divider, 32 by 16 bits, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module oafr_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             done,
  output logic [31:0]      quot
);
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] q_r, q_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] dsr_r, dsr_nxt;
  logic [16:0] rem_sh;
  logic        ge;

  always_comb begin
    rem_sh   = {rem_r, q_r[31]};
    ge       = (rem_sh >= {1'b0, dsr_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      // shift in one dividend bit, subtract when it fits
      rem_nxt = ge ? 16'(rem_sh - {1'b0, dsr_r}) : rem_sh[15:0];
      q_nxt   = {q_r[30:0], ge};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

`default_nettype wire

### hdl/oafr_dp.sv
// ----------------------------------------------------------------------------
// oafr_dp
// Datapath: configuration, decoder state, frame store and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module oafr_dp #(
  parameter int DATA_BITS    = 56,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire oafr_pkg::oafr_cmd_t           cmd,
  output oafr_pkg::oafr_sts_t                sts,
  input  wire oafr_pkg::in_item_t            in_data,
  input  wire logic                          cfg_we,
  input  wire logic [oafr_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [oafr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic [31:0]                        div_dividend,
  output logic [15:0]                        div_divisor,
  input  wire logic [31:0]                   div_quot,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output oafr_pkg::out_item_t                out_data
);
  import oafr_pkg::*;

  localparam int SW     = SAMPLE_WIDTH;
  localparam int SUM_W  = SAMPLE_WIDTH + 10;
  localparam int BITS_W = $clog2(DATA_BITS + 1);

  // configuration
  logic [15:0] settle_r;
  logic [10:0] csamples_r;
  logic [7:0]  minedges_r;
  logic [9:0]  npad_r;

  // decoder state
  phase_t             mode_r, mode_nxt;
  logic [15:0]        tick_r, tick_nxt;
  logic [SUM_W-1:0]   csum_r, csum_nxt;
  logic [10:0]        ccount_r, ccount_nxt;
  logic [SW-1:0]      clow_r, clow_nxt;
  logic [SW-1:0]      chigh_r, chigh_nxt;
  logic [15:0]        thr_r, thr_nxt;
  logic               wb_r, wb_nxt;
  logic [15:0]        last_r, last_nxt;
  logic [31:0]        esum_r, esum_nxt;
  logic [15:0]        ecount_r, ecount_nxt;
  logic [15:0]        period_r, period_nxt;
  logic [15:0]        next_r, next_nxt;
  logic [BITS_W-1:0]  bits_r, bits_nxt;
  logic [FRAME_BITS-1:0] frame_r, frame_nxt;
  logic               dsel_r, dsel_nxt;
  in_item_t           item_r;
  logic               ovalid_r, ovalid_nxt;
  out_item_t          out_r;

  // working values
  logic [SW-1:0] rd;
  logic          bright;
  logic [15:0]   tick_inc;
  logic [10:0]   ccount_inc;
  logic [10:0]   target;
  logic [15:0]   interval;
  logic [15:0]   ecount_inc;
  logic [BITS_W-1:0] bits_inc;
  logic [16:0]   margin;
  logic [16:0]   half_limit;
  logic [7:0]    byte_sum;

  function automatic logic frame_ok(input logic [FRAME_BITS-1:0] f);
    logic ok;
    ok = 1'b1;
    if (f[7:0] > YEAR_MAX) ok = 1'b0;
    if (f[15:8] < 8'd1 || f[15:8] > MONTH_MAX) ok = 1'b0;
    if (f[23:16] < 8'd1 || f[23:16] > DAY_MAX) ok = 1'b0;
    if (f[31:24] > HOUR_MAX) ok = 1'b0;
    if (f[39:32] > MINSEC_MAX) ok = 1'b0;
    if (f[47:40] > MINSEC_MAX) ok = 1'b0;
    return ok;
  endfunction

  always_comb begin
    rd         = item_r.sample[SW-1:0];
    bright     = (16'(rd) < thr_r);
    tick_inc   = tick_r + 16'd1;
    ccount_inc = ccount_r + 11'd1;
    ecount_inc = ecount_r + 16'd1;
    bits_inc   = bits_r + BITS_W'(1);
    interval   = tick_inc - last_r;
    half_limit = 17'(period_r) + 17'(period_r >> 1);
    margin     = 17'(chigh_r - clow_r) + 17'(npad_r);
    if (csamples_r == 11'd0) begin
      target = 11'd1;
    end else if (csamples_r > 11'(CALIB_MAX)) begin
      target = 11'(CALIB_MAX);
    end else begin
      target = csamples_r;
    end

    mode_nxt     = mode_r;
    tick_nxt     = tick_r;
    csum_nxt     = csum_r;
    ccount_nxt   = ccount_r;
    clow_nxt     = clow_r;
    chigh_nxt    = chigh_r;
    thr_nxt      = thr_r;
    wb_nxt       = wb_r;
    last_nxt     = last_r;
    esum_nxt     = esum_r;
    ecount_nxt   = ecount_r;
    period_nxt   = period_r;
    next_nxt     = next_r;
    bits_nxt     = bits_r;
    frame_nxt    = frame_r;
    dsel_nxt     = dsel_r;
    sts.need_div = 1'b0;
    sts.out_free = !ovalid_r || !out_stall;

    if (cmd.exec) begin
      if (item_r.action) begin
        mode_nxt   = PH_CAL;
        tick_nxt   = '0;
        csum_nxt   = '0;
        ccount_nxt = '0;
        clow_nxt   = '1;
        chigh_nxt  = '0;
        thr_nxt    = '0;
        wb_nxt     = 1'b0;
        last_nxt   = '0;
        esum_nxt   = '0;
        ecount_nxt = '0;
        period_nxt = '0;
        next_nxt   = '0;
        bits_nxt   = '0;
        frame_nxt  = '0;
      end else begin
        tick_nxt = tick_inc;
        case (mode_r)
          PH_CAL: begin
            if (tick_inc > settle_r) begin
              csum_nxt   = csum_r + SUM_W'(rd);
              ccount_nxt = ccount_inc;
              if (rd < clow_r) clow_nxt = rd;
              if (rd > chigh_r) chigh_nxt = rd;
              if (ccount_inc >= target) begin
                sts.need_div = 1'b1;
                dsel_nxt     = 1'b0;
              end
            end
          end
          PH_LISTEN: begin
            if (bright && !wb_r) begin
              last_nxt = tick_inc;
              mode_nxt = PH_PRE;
            end
            wb_nxt = bright;
          end
          PH_PRE: begin
            if (bright != wb_r) begin
              esum_nxt   = esum_r + 32'(interval);
              ecount_nxt = ecount_inc;
              last_nxt   = tick_inc;
              if (ecount_inc != 16'd0 && ecount_inc >= 16'(minedges_r)) begin
                sts.need_div = 1'b1;
                dsel_nxt     = 1'b1;
              end
            end else if (period_r != 16'd0) begin
              if (17'(interval) > half_limit) begin
                mode_nxt = PH_DATA;
                bits_nxt = '0;
                next_nxt = last_r + (period_r << 1) + (period_r >> 1);
              end
            end
            wb_nxt = bright;
          end
          PH_DATA: begin
            if (tick_inc >= next_r) begin
              if (bright && bits_r < BITS_W'(FRAME_BITS)) begin
                frame_nxt[bits_r[5:0]] = 1'b1;
              end
              bits_nxt = bits_inc;
              next_nxt = next_r + period_r;
              if (bits_inc >= BITS_W'(DATA_BITS)) begin
                mode_nxt = frame_ok(frame_nxt) ? PH_OK : PH_ERR;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (cmd.fin) begin
      if (dsel_r) begin
        period_nxt = (div_quot[31:16] != 16'd0) ? 16'hFFFF : div_quot[15:0];
      end else begin
        thr_nxt  = (div_quot[16:0] > margin) ? 16'(div_quot[16:0] - margin) : 16'd0;
        wb_nxt   = 1'b0;
        mode_nxt = PH_LISTEN;
      end
    end
  end

  assign div_dividend = dsel_r ? esum_r : 32'(csum_r);
  assign div_divisor  = dsel_r ? ecount_r : 16'(ccount_r);

  always_comb begin
    byte_sum = frame_r[7:0] + frame_r[15:8] + frame_r[23:16] + frame_r[31:24]
             + frame_r[39:32] + frame_r[47:40];
    ovalid_nxt   = ovalid_r;
    if (cmd.load_out) begin
      ovalid_nxt = 1'b1;
    end else if (ovalid_r && !out_stall) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r   <= 16'd192;
      csamples_r <= 11'd64;
      minedges_r <= 8'd4;
      npad_r     <= 10'd10;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SETTLE:   settle_r   <= cfg_wdata;
        CFG_CSAMPLES: csamples_r <= cfg_wdata[10:0];
        CFG_MINEDGES: minedges_r <= cfg_wdata[7:0];
        CFG_NPAD:     npad_r     <= cfg_wdata[9:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= PH_CAL;
      tick_r   <= '0;
      csum_r   <= '0;
      ccount_r <= '0;
      clow_r   <= '1;
      chigh_r  <= '0;
      thr_r    <= '0;
      wb_r     <= 1'b0;
      last_r   <= '0;
      esum_r   <= '0;
      ecount_r <= '0;
      period_r <= '0;
      next_r   <= '0;
      bits_r   <= '0;
      frame_r  <= '0;
      dsel_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      tick_r   <= tick_nxt;
      csum_r   <= csum_nxt;
      ccount_r <= ccount_nxt;
      clow_r   <= clow_nxt;
      chigh_r  <= chigh_nxt;
      thr_r    <= thr_nxt;
      wb_r     <= wb_nxt;
      last_r   <= last_nxt;
      esum_r   <= esum_nxt;
      ecount_r <= ecount_nxt;
      period_r <= period_nxt;
      next_r   <= next_nxt;
      bits_r   <= bits_nxt;
      frame_r  <= frame_nxt;
      dsel_r   <= dsel_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // item and result words
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    if (cmd.load_out) begin
      out_r.phase           <= mode_r;
      out_r.bit_count       <= bits_r[5:0];
      out_r.period_ticks    <= period_r;
      out_r.level_threshold <= thr_r;
      out_r.year_field      <= frame_r[7:0];
      out_r.month_field     <= frame_r[15:8];
      out_r.day_field       <= frame_r[23:16];
      out_r.hour_field      <= frame_r[31:24];
      out_r.minute_field    <= frame_r[39:32];
      out_r.second_field    <= frame_r[47:40];
      out_r.sum_ok          <= (byte_sum == frame_r[55:48]);
    end
  end

  assign out_valid = ovalid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

### hdl/oafr_ctl.sv
// ----------------------------------------------------------------------------
// oafr_ctl
// Sequencer: accept a word, update the decoder, run the divider when needed, emit result.
// ----------------------------------------------------------------------------
`default_nettype none

module oafr_ctl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output oafr_pkg::oafr_cmd_t      cmd,
  input  wire oafr_pkg::oafr_sts_t sts,
  output logic                     div_start,
  input  wire logic                div_done
);
  import oafr_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC:   state_nxt = sts.need_div ? ST_DSTART : ST_OUT;
      ST_DSTART: state_nxt = ST_DWAIT;
      ST_DWAIT:  if (div_done) state_nxt = ST_FIN;
      ST_FIN:    state_nxt = ST_OUT;
      ST_OUT:    if (sts.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = (state_r != ST_IDLE);
    cmd.capture  = (state_r == ST_IDLE) && in_valid;
    cmd.exec     = (state_r == ST_EXEC);
    cmd.fin      = (state_r == ST_FIN);
    cmd.load_out = (state_r == ST_OUT) && sts.out_free;
    div_start    = (state_r == ST_DSTART);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/oafr_checker.sv
// ----------------------------------------------------------------------------
// oafr_checker
// Port-level checks for the optical autobaud frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

`include "optical_autobaud_frame_receiver_assert.svh"

module oafr_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire oafr_pkg::out_item_t out_data
);
  import oafr_pkg::*;

  // a held result keeps its word
  `OAFR_ASSERT_NEXT(a_out_hold, clk, rst_n, rst_n && out_valid && out_stall, out_valid)
  `OAFR_ASSERT_NEXT(a_out_stable, clk, rst_n, rst_n && out_valid && out_stall, $stable(out_data))

  // one word in work at a time: busy right after acceptance
  `OAFR_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, rst_n && in_valid && !in_stall, in_stall)

  // no bits and no period while calibrating
  `OAFR_ASSERT_SAME(a_cal_clean, clk, rst_n, out_valid && out_data.phase == PH_CAL,
                    out_data.bit_count == 6'd0 && out_data.period_ticks == 16'd0)

endmodule

bind optical_autobaud_frame_receiver oafr_checker u_chk (.*);

`default_nettype wire
